// File: rtl/bal_pkg.sv
// bal_pkg: shared sizes, codes, payload structs and helper functions
// for the bounded array list; no dependencies
package bal_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 4;
  localparam int FILL_W   = 5;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOCATE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill_count;
  } res_t;

  typedef struct packed {
    kind_e             kind;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qport_t;

  function automatic logic [POS_W-1:0] pos_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+POS_W-1:0] wide;
    wide = {{POS_W{1'b0}}, idx};
    return wide[POS_W-1:0];
  endfunction

  function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+FILL_W-1:0] wide;
    wide = {{FILL_W{1'b0}}, cnt};
    return wide[FILL_W-1:0];
  endfunction

endpackage

// File: rtl/bal_ram.sv
// bal_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/bal_front.sv
// bal_front: takes requests, decodes the opcode and holds them in a short queue
// depends on bal_pkg
module bal_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bal_pkg::req_t req_i,
  output bal_pkg::qport_t q_o,
  input  logic          pop_i
);
  import bal_pkg::*;

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              cmd_in;
  logic              push;

  always_comb begin
    cmd_in.value = req_i.value;
    unique case (req_i.opcode)
      OP_INSERT: cmd_in.kind = KIND_INSERT;
      OP_DELETE: cmd_in.kind = KIND_DELETE;
      OP_LOCATE: cmd_in.kind = KIND_LOCATE;
      default:   cmd_in.kind = KIND_NOP;
    endcase
  end

  assign busy = (cnt_q == QCNT_W'(QDEPTH));
  assign push = start && !busy;

  assign q_o.valid = (cnt_q != '0);
  assign q_o.cmd   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: rtl/bal_back.sv
// bal_back: executes queued commands against the entry ram, scan and shift
// depends on bal_pkg and bal_ram
module bal_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bal_pkg::qport_t q_i,
  output logic            pop_o,
  output logic            res_valid_o,
  output bal_pkg::res_t   res_o
);
  import bal_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [IDX_W-1:0] idx_q, idx_d, pos_q, pos_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;
  logic             hit, last;

  bal_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign hit  = (rdata == cmd_q.value);
  // idx is the last live entry (old count in scan, new count in shift)
  assign last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    count_d     = count_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata;
    raddr       = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          cmd_d = q_i.cmd;
          case (q_i.cmd.kind)
            KIND_INSERT: begin
              res_valid_d = 1'b1;
              if (count_q < CNT_W'(CAPACITY)) begin
                we      = 1'b1;
                waddr   = count_q[IDX_W-1:0];
                wdata   = q_i.cmd.value;
                count_d = count_q + CNT_W'(1);
                res_d   = '{ST_OK, '0, fill_of(count_q + CNT_W'(1))};
              end else begin
                res_d   = '{ST_FULL, '0, fill_of(count_q)};
              end
            end
            KIND_DELETE, KIND_LOCATE: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = '{ST_MISS, '0, fill_of(count_q)};
              end else begin
                idx_d   = '0;
                raddr   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = '{ST_OK, '0, fill_of(count_q)};
            end
          endcase
        end
      end

      S_SCAN: begin
        raddr = idx_q + IDX_W'(1);
        if (hit) begin
          if (cmd_q.kind == KIND_LOCATE) begin
            res_valid_d = 1'b1;
            res_d       = '{ST_OK, pos_of(idx_q), fill_of(count_q)};
            state_d     = S_IDLE;
          end else begin
            count_d = count_q - CNT_W'(1);
            if (last) begin
              res_valid_d = 1'b1;
              res_d       = '{ST_OK, pos_of(idx_q), fill_of(count_q - CNT_W'(1))};
              state_d     = S_IDLE;
            end else begin
              pos_d   = idx_q;
              state_d = S_SHIFT;
            end
          end
        end else if (last) begin
          res_valid_d = 1'b1;
          res_d       = '{ST_MISS, '0, fill_of(count_q)};
          state_d     = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_SHIFT: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = rdata;
        raddr = idx_q + IDX_W'(2);
        if (last) begin
          res_valid_d = 1'b1;
          res_d       = '{ST_OK, pos_of(pos_q), fill_of(count_q)};
          state_d     = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/bounded_array_list.sv
// bounded_array_list: top level of the bounded unsorted list
// depends on bal_pkg, bal_front, bal_back and bal_ram
//
// usage
// - a request transaction (opcode, value on req_i) is taken at a rising edge
//   where start is high and busy is low
// - opcodes: insert at end, delete first match, locate first match; the
//   unused code only reports the current fill count
// - every request gives exactly one result transaction on res_o, marked by
//   res_valid_o for a single cycle; the receiver cannot stall, so the result
//   must be captured in that cycle
// - requests sit in a two-deep queue; busy is high while the queue is full
// - with the back end idle, insert, the unused code and a miss on an empty
//   list are answered from the queue head without a scan; locate and delete
//   scan the entries in order, up to the fill count, and a delete that hits
//   then shifts every later entry down by one slot
// - throughput is set by the back end's single ram read port, one compare or
//   one shift move per cycle; the back end takes the next request only once
//   the last one has its result
// - reset empties the list and the queue; entries are never cleared
module bounded_array_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bal_pkg::req_t req_i,
  output logic          res_valid_o,
  output bal_pkg::res_t res_o
);
  import bal_pkg::*;

  // front to back queue head and pop
  qport_t q;
  logic   pop;

  // front end: request accept, opcode decode, command queue
  bal_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .q_o   (q),
    .pop_i (pop)
  );

  // back end: list storage, scan and shift sequencer, result register
  bal_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_i        (q),
    .pop_o      (pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

// File: dv/bal_checker.sv
// bal_checker: watches the request and result channels of bounded_array_list,
// keeps its own copy of the list, predicts every result and compares it
// depends on bal_pkg for the payload structs, widths and codes
module bal_checker
  import bal_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic res_valid_i,
  input  res_t res_i,
  output int   fail_count_o,
  output int   pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [VAL_W-1:0] list_mem [CAPACITY];
  int unsigned      list_len;
  res_t             expected_results [$];
  res_t             oldest;
  int               mismatches;

  // applies one request to the shadow list and returns the result it gives
  function automatic res_t apply_request(req_t rq);
    res_t        r;
    int unsigned hit;
    r.status   = ST_OK;
    r.position = '0;
    case (kind_e'(rq.opcode))
      KIND_INSERT: begin
        if (list_len < CAPACITY) begin
          list_mem[list_len] = rq.value;
          list_len++;
        end else begin
          r.status = ST_FULL;
        end
      end
      KIND_DELETE, KIND_LOCATE: begin
        hit = 0;
        while (hit < list_len && list_mem[hit] != rq.value) hit++;
        if (hit == list_len) begin
          r.status = ST_MISS;
        end else begin
          r.position = POS_W'(hit);
          if (kind_e'(rq.opcode) == KIND_DELETE) begin
            for (int unsigned i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    r.fill_count = FILL_W'(list_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      mismatches = 0;
      expected_results.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no transaction outstanding: status=%0d position=%0d fill=%0d",
                     $time, res_i.status, res_i.position, res_i.fill_count);
        end else begin
          oldest = expected_results.pop_front();
          if (res_i.status !== oldest.status || res_i.position !== oldest.position ||
              res_i.fill_count !== oldest.fill_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected status=%0d position=%0d fill=%0d, got status=%0d position=%0d fill=%0d",
                       $time, oldest.status, oldest.position, oldest.fill_count,
                       res_i.status, res_i.position, res_i.fill_count);
          end
        end
      end
      // a result cannot appear in the cycle its request is taken, so the
      // new expectation goes in after the comparison above
      if (start_i && !busy_i) expected_results.push_back(apply_request(req_i));
      pending_o <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: dv/tb_bounded_array_list.sv
// tb_bounded_array_list: stimulus, clock, reset, watchdog and verdict for
// bounded_array_list; checking is done by bal_checker beside the block
// depends on bal_pkg, bal_checker and the bounded_array_list rtl
module tb_bounded_array_list;

  timeunit 1ns;
  timeprecision 1ps;

  import bal_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES     = 64;    // quiet time after the last result
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int POOL_N          = 6;
  localparam int MAX_GAP         = 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t req;
  logic res_valid;
  res_t res;
  int   fail_count;
  int   pending;

  // per phase: sender idle percentage, insert and delete shares (locate gets
  // the rest, minus a few percent of the unused opcode)
  int phase_idle [NUM_PHASES] = '{0, 56, 7, 56, 0, 7};
  int phase_ins  [NUM_PHASES] = '{45, 70, 40, 20, 45, 60};
  int phase_del  [NUM_PHASES] = '{35, 10, 35, 60, 40, 25};

  int               idle_pct;
  logic [VAL_W-1:0] value_pool [POOL_N];
  int               stall_cycles = 0;

  bounded_array_list u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bal_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request transaction: optional idle gap, then hold start until the
  // block takes it; returns at the accepting edge so the next call can keep
  // start high without a bubble
  task automatic issue(logic [1:0] op, logic [VAL_W-1:0] val);
    int   gap;
    req_t item;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.opcode = op;
    item.value  = val;
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  // sender holds off until every outstanding transaction has its result;
  // the extra edge lets the checker count the request just taken
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly values from a small pool so deletes and locates hit, some fully
  // random values so every bit of the field toggles
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return value_pool[$urandom_range(POOL_N - 1)];
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_op(int ins_pct, int del_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return KIND_NOP;
    if (r < 4 + ins_pct) return KIND_INSERT;
    if (r < 4 + ins_pct + del_pct) return KIND_DELETE;
    return KIND_LOCATE;
  endfunction

  // fresh pool per phase, one slot always takes a boundary value
  function automatic void refresh_pool();
    logic [VAL_W-1:0] corners [4];
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    for (int i = 0; i < POOL_N; i++) value_pool[i] = $urandom();
    value_pool[0] = corners[$urandom_range(3)];
  endfunction

  // watchdog: too long without any transaction means the block hung
  always @(posedge clk) begin
    if ((start && !busy) || res_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("bounded_array_list test failed");
      $finish;
    end
  end

  initial begin
    start    = 1'b0;
    req      = '0;
    rst_n    = 1'b0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list corner cases and the unused opcode
    issue(KIND_LOCATE, 32'h0000_0000);
    issue(KIND_DELETE, 32'hffff_ffff);
    issue(KIND_NOP,    32'haaaa_aaaa);
    // extremes of the value field, with a duplicate of the most negative
    issue(KIND_INSERT, 32'h8000_0000);
    issue(KIND_INSERT, 32'h7fff_ffff);
    issue(KIND_INSERT, 32'hffff_ffff);
    issue(KIND_INSERT, 32'h8000_0000);
    // first match wins for locate and delete; miss on a non-empty list
    issue(KIND_LOCATE, 32'h8000_0000);
    issue(KIND_LOCATE, 32'h0000_0000);
    issue(KIND_DELETE, 32'h8000_0000);
    issue(KIND_DELETE, 32'h0000_0000);
    // fill to capacity, then insert when full
    for (int i = 0; i < 13; i++) issue(KIND_INSERT, 32'h5555_5555 ^ VAL_W'(i));
    issue(KIND_INSERT, 32'h1234_5678);
    // last slot for locate and delete, then delete at the head with a full shift
    issue(KIND_LOCATE, 32'h5555_5559);
    issue(KIND_DELETE, 32'h5555_5559);
    issue(KIND_DELETE, 32'h7fff_ffff);
    wait_drained();

    // random phases: balanced, fill-heavy and drain-heavy mixes under
    // different sender idle rates, with a full drain between phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = phase_idle[p];
      refresh_pool();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        issue(pick_op(phase_ins[p], phase_del[p]), pick_value());
        if ($urandom_range(199) == 0) wait_drained();
      end
      wait_drained();
    end

    // quiet tail to catch stray results
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bounded_array_list test passed");
    end else begin
      $display("bounded_array_list test failed");
    end
    $finish;
  end

endmodule
